>>> hdl/bayer_demosaic_malvar_top_defines.svh
// Assertion macros shared by the demosaic modules.
// Included by every file that asserts; no other dependencies.
`ifndef BAYER_DEMOSAIC_MALVAR_TOP_DEFINES_SVH
`define BAYER_DEMOSAIC_MALVAR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdm assertion failed");
`define BDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdm assertion failed");
`else
`define BDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bdm_pkg.sv
// Shared types and constants for the Bayer demosaic block.
// No dependencies.
package bdm_pkg;
    localparam int PIX_W        = 14;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT   = 8192;
    localparam int MIN_SIZE     = 8;
    localparam int QDEPTH       = 4;
    localparam int ACC_W        = 26;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_MAX    = 2'd2;

    localparam logic [1:0] PH_R  = 2'd0;
    localparam logic [1:0] PH_GR = 2'd1;
    localparam logic [1:0] PH_GB = 2'd2;
    localparam logic [1:0] PH_B  = 2'd3;

    // one window column plus what the back end needs for it
    typedef struct packed {
        logic [4:0][PIX_W-1:0] col;
        logic                  has_result;
        logic [12:0]           row;
        logic [11:0]           colpos;
        logic                  last;
        logic [1:0]            phase;
    } bdm_col_t;
endpackage

>>> hdl/bdm_front.sv
// Front end: position counters, classification and the four-line store.
// Depends on bdm_pkg.
module bdm_front import bdm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_raw_pixel,
    input  logic [12:0]      frame_width,
    input  logic [13:0]      frame_height,
    input  logic [$clog2(QDEPTH+1)-1:0] q_count,
    output logic             push,
    output bdm_col_t         push_data
);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]      col_reg, col_next;
    logic [12:0]        row_reg, row_next;
    logic [CW:0]        w_eff;
    logic [13:0]        h_eff, r_ext;
    logic [CW:0]        c_ext;
    logic               acc;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic               s1_has_reg, s1_last_reg;
    logic [12:0]        s1_row_reg;
    logic [11:0]        s1_col_reg;
    logic [4*PIX_W-1:0] rd_reg;
    logic [4*PIX_W-1:0] mem [MAX_WIDTH];
    logic               has, last;

    assign acc     = s_valid && s_ready;
    assign s_ready = (32'(q_count) + 32'(s1_valid_reg)) < QDEPTH;

    always_comb begin
        if (frame_width < 13'(MIN_SIZE)) begin
            w_eff = (CW+1)'(MIN_SIZE);
        end else if ({1'b0, frame_width} > 14'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(frame_width);
        end
        if (frame_height < 14'(MIN_SIZE)) begin
            h_eff = 14'(MIN_SIZE);
        end else if (frame_height > 14'(MAX_HEIGHT)) begin
            h_eff = 14'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height;
        end
        c_ext = {1'b0, col_reg};
        r_ext = {1'b0, row_reg};
        has  = (r_ext >= 14'd4) && (c_ext >= (CW+1)'(4)) && (c_ext < w_eff) && (r_ext < h_eff);
        last = (r_ext == h_eff - 14'd1) && (c_ext == w_eff - (CW+1)'(1));
        if (c_ext >= w_eff - (CW+1)'(1)) begin
            col_next = '0;
            row_next = (r_ext >= h_eff - 14'd1) ? '0 : row_reg + 13'd1;
        end else begin
            col_next = col_reg + CW'(1);
            row_next = (r_ext >= h_eff) ? '0 : row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
            if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_pix_reg  <= s_raw_pixel;
            s1_addr_reg <= col_reg;
            s1_has_reg  <= has;
            s1_last_reg <= last;
            s1_row_reg  <= row_reg - 13'd2;
            s1_col_reg  <= 12'(col_reg - CW'(2));
        end
    end

    // line store: read on accept, write the rolled column back in the following cycle
    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg <= mem[col_reg];
        end
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= {s1_pix_reg, rd_reg[4*PIX_W-1:PIX_W]};
        end
    end

    assign push = s1_valid_reg;
    always_comb begin
        push_data.col[0]     = rd_reg[PIX_W-1:0];
        push_data.col[1]     = rd_reg[2*PIX_W-1:PIX_W];
        push_data.col[2]     = rd_reg[3*PIX_W-1:2*PIX_W];
        push_data.col[3]     = rd_reg[4*PIX_W-1:3*PIX_W];
        push_data.col[4]     = s1_pix_reg;
        push_data.has_result = s1_has_reg;
        push_data.row        = s1_row_reg;
        push_data.colpos     = s1_col_reg;
        push_data.last       = s1_last_reg;
        push_data.phase      = {s1_row_reg[0], s1_col_reg[0]};
    end
endmodule

>>> hdl/bdm_queue.sv
// Short queue of window columns between front and back end.
// Depends on bdm_pkg and the assertion macro header.
`include "bayer_demosaic_malvar_top_defines.svh"
module bdm_queue import bdm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bdm_col_t push_data,
    input  logic     pop,
    output logic     q_valid,
    output bdm_col_t q_data,
    output logic [$clog2(QDEPTH+1)-1:0] q_count
);
    localparam int PW = $clog2(QDEPTH);

    bdm_col_t                    ent_reg [QDEPTH];
    logic [PW-1:0]               wp_reg, rp_reg;
    logic [$clog2(QDEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (pop) begin
                rp_reg <= rp_reg + PW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_data;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_data  = ent_reg[rp_reg];
    assign q_count = cnt_reg;

    `BDM_ASSERT_IMP(a_no_overflow, aclk, aresetn, cnt_reg == QDEPTH, !push || pop)
    `BDM_ASSERT_IMP(a_no_underflow, aclk, aresetn, cnt_reg == 0, !pop)
    `BDM_ASSERT_NXT(a_cnt_up, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
endmodule

>>> hdl/bdm_back.sv
// Back end: 5x5 window, Malvar kernels, clamp and output register.
// Depends on bdm_pkg.
module bdm_back import bdm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  bdm_col_t         q_data,
    output logic             pop,
    input  logic [13:0]      pixel_max,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_red,
    output logic [PIX_W-1:0] m_green,
    output logic [PIX_W-1:0] m_blue,
    output logic [12:0]      m_out_row,
    output logic [11:0]      m_out_col,
    output logic             m_frame_last
);
    typedef struct packed {
        logic [12:0] row;
        logic [11:0] colpos;
        logic        last;
        logic [1:0]  phase;
    } meta_t;

    logic [PIX_W-1:0] win_reg [5][5];
    logic             en;
    logic             v1_reg, v2_reg, v3_reg, mv_reg;
    meta_t            m1_reg, m2_reg, m3_reg, mo_reg;
    logic [PIX_W-1:0] ctr_reg;
    logic [PIX_W:0]   h1_reg, v1s_reg, h2_reg, v2s_reg;
    logic [PIX_W+1:0] dg_reg;
    logic signed [ACC_W-1:0] c_s, h1_s, v1_s, h2_s, v2_s, dg_s;
    logic signed [ACC_W-1:0] pass, grn, opp, hor, ver;
    logic signed [ACC_W-1:0] rr_reg, gg_reg, bb_reg;
    logic [PIX_W-1:0] r_o_reg, g_o_reg, b_o_reg;

    assign en  = !mv_reg || m_ready;
    assign pop = en && q_valid;

    // shift window left, new column enters at the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 5; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (pop) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][4] <= q_data.col[i];
            end
        end
    end

    always_comb begin
        c_s  = ACC_W'(ctr_reg);
        h1_s = ACC_W'(h1_reg);
        v1_s = ACC_W'(v1s_reg);
        h2_s = ACC_W'(h2_reg);
        v2_s = ACC_W'(v2s_reg);
        dg_s = ACC_W'(dg_reg);
        pass = c_s <<< 7;
        grn  = ((c_s <<< 2) + ((h1_s + v1_s) <<< 1) - (h2_s + v2_s)) <<< 4;
        opp  = ((c_s * ACC_W'(12)) + (dg_s <<< 2) - ((h2_s + v2_s) * ACC_W'(3))) <<< 3;
        hor  = ((c_s * ACC_W'(10)) + (h1_s <<< 3) - (h2_s <<< 1) - (dg_s <<< 1)
                + v2_s) <<< 3;
        ver  = ((c_s * ACC_W'(10)) + (v1_s <<< 3) - (v2_s <<< 1) - (dg_s <<< 1)
                + h2_s) <<< 3;
    end

    function automatic logic [PIX_W-1:0] finish(input logic signed [ACC_W-1:0] a,
                                                input logic [13:0] pmax);
        logic [ACC_W-8:0] v;
        v = a[ACC_W-1] ? '0 : a[ACC_W-1:7];
        if (v > (ACC_W-7)'(pmax)) begin
            v = (ACC_W-7)'(pmax);
        end
        return PIX_W'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= q_valid && q_data.has_result;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            mv_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg  <= '{row: q_data.row, colpos: q_data.colpos,
                         last: q_data.last, phase: q_data.phase};
            ctr_reg <= win_reg[2][2];
            h1_reg  <= {1'b0, win_reg[2][1]} + {1'b0, win_reg[2][3]};
            v1s_reg <= {1'b0, win_reg[1][2]} + {1'b0, win_reg[3][2]};
            h2_reg  <= {1'b0, win_reg[2][0]} + {1'b0, win_reg[2][4]};
            v2s_reg <= {1'b0, win_reg[0][2]} + {1'b0, win_reg[4][2]};
            dg_reg  <= (PIX_W+2)'(win_reg[1][1]) + (PIX_W+2)'(win_reg[1][3])
                     + (PIX_W+2)'(win_reg[3][1]) + (PIX_W+2)'(win_reg[3][3]);
            m2_reg  <= m1_reg;
            case (m2_reg.phase)
                PH_R: begin
                    rr_reg <= pass; gg_reg <= grn; bb_reg <= opp;
                end
                PH_GR: begin
                    rr_reg <= hor; gg_reg <= pass; bb_reg <= ver;
                end
                PH_GB: begin
                    rr_reg <= ver; gg_reg <= pass; bb_reg <= hor;
                end
                default: begin
                    rr_reg <= opp; gg_reg <= grn; bb_reg <= pass;
                end
            endcase
            m3_reg  <= m2_reg;
            r_o_reg <= finish(rr_reg, pixel_max);
            g_o_reg <= finish(gg_reg, pixel_max);
            b_o_reg <= finish(bb_reg, pixel_max);
            mo_reg  <= m3_reg;
        end
    end

    assign m_valid      = mv_reg;
    assign m_red        = r_o_reg;
    assign m_green      = g_o_reg;
    assign m_blue       = b_o_reg;
    assign m_out_row    = mo_reg.row;
    assign m_out_col    = mo_reg.colpos;
    assign m_frame_last = mo_reg.last;
endmodule

>>> hdl/bayer_demosaic_malvar_top.sv
// Bayer RGGB demosaic (Malvar-He-Cutler 5x5), one pixel per clock while m_ready
// is high. The block takes raw samples in raster order and gives one RGB word per
// interior pixel (two pixels in from every border) with its row, column and a
// frame-end flag. Sustained rate is one pixel per cycle: the line store is read on
// accept and rewritten in the following cycle via its separate write port; every
// stage advances once per cycle unless m_ready stalls. m_valid is registered.
// A stalled m_ready holds the back end and, once the queue and front register hold
// four, s_ready. Write configuration only while idle; the block does not check.
// Depends on bdm_pkg, bdm_front, bdm_queue, bdm_back.
module bayer_demosaic_malvar_top import bdm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [13:0]      cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_raw_pixel,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_red,
    output logic [PIX_W-1:0] m_green,
    output logic [PIX_W-1:0] m_blue,
    output logic [12:0]      m_out_row,
    output logic [11:0]      m_out_col,
    output logic             m_frame_last
);
    logic [12:0] fw_reg;
    logic [13:0] fh_reg, pmax_reg;
    logic        push, pop, q_valid;
    bdm_col_t    push_data, q_data;
    logic [$clog2(QDEPTH+1)-1:0] q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= 13'd4096;
            fh_reg   <= 14'd2832;
            pmax_reg <= 14'd16383;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg   <= cfg_wr_data[12:0];
                REG_FRAME_HEIGHT: fh_reg   <= cfg_wr_data;
                REG_PIXEL_MAX:    pmax_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    bdm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_raw_pixel(s_raw_pixel),
        .frame_width(fw_reg), .frame_height(fh_reg),
        .q_count(q_count), .push(push), .push_data(push_data)
    );

    bdm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_data(push_data), .pop(pop),
        .q_valid(q_valid), .q_data(q_data), .q_count(q_count)
    );

    bdm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(q_data), .pop(pop), .pixel_max(pmax_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_frame_last(m_frame_last)
    );
endmodule

>>> test/bayer_demosaic_malvar_top_tb.sv
// Testbench for bayer_demosaic_malvar_top: whole frames streamed through the
// block, each RGB word checked against a local Malvar 5x5 predictor.
// Depends on bdm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module bayer_demosaic_malvar_top_tb;
    import bdm_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int RANDOM_ITEMS = 560;

    typedef enum int {FILL_FLAT, FILL_CHECKER, FILL_RANDOM, FILL_STRIPES} fill_e;

    typedef struct {
        logic [13:0] red;
        logic [13:0] green;
        logic [13:0] blue;
        logic [12:0] row;
        logic [11:0] col;
        logic        last;
    } rgb_word_t;

    typedef struct {
        int    width;
        int    height;
        int    pmax;
        fill_e fill;
        int    level;
        int    flat_color;  // -1: predictor only
    } frame_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [13:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [13:0] s_raw_pixel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_red, m_green, m_blue;
    logic [12:0] m_out_row;
    logic [11:0] m_out_col;
    logic        m_frame_last;

    bayer_demosaic_malvar_top DUT (.*);

    always #5 aclk = ~aclk;

    // predictor state
    bit [13:0] line_mem[4][4096];
    bit [13:0] win[5][5];
    int        col_pos, row_pos;
    int        cfg_width = 4096, cfg_height = 2832, cfg_pmax = 16383;
    rgb_word_t rgb_pending[$];
    int        flat_color = -1;

    int  errors = 0;
    int  cycles = 0;
    int  words_seen = 0;
    int  frames_sent = 0;
    bit  idle_on = 1'b1;

    function automatic logic [13:0] saturate(int a);
        int v;
        if (a < 0) a = 0;
        v = a >>> 7;
        if (v > cfg_pmax) v = cfg_pmax;
        return v[13:0];
    endfunction

    function automatic int wp(int dy, int dx);
        return int'(win[dy + 2][dx + 2]);
    endfunction

    function automatic void demosaic_step(logic [13:0] pix);
        int w, h, c, r;
        int ctr, h1, v1, h2, v2, dg;
        int pass, grn, opp, hor, ver, rr, gg, bb;
        logic [1:0] ph;
        rgb_word_t e;
        w = cfg_width;  h = cfg_height;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < MIN_SIZE) h = MIN_SIZE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        c = col_pos;  r = row_pos;
        if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) win[i][j] = win[i][j + 1];
            win[i][4] = (i < 4) ? line_mem[i][c] : pix;
        end
        for (int i = 0; i < 3; i++) line_mem[i][c] = line_mem[i + 1][c];
        line_mem[3][c] = pix;

        if (r >= 4 && c >= 4 && c < w && r < h) begin
            ctr = wp(0, 0);
            h1 = wp(0, -1) + wp(0, 1);   v1 = wp(-1, 0) + wp(1, 0);
            h2 = wp(0, -2) + wp(0, 2);   v2 = wp(-2, 0) + wp(2, 0);
            dg = wp(-1, -1) + wp(-1, 1) + wp(1, -1) + wp(1, 1);
            pass = 128 * ctr;
            grn = 16 * (4 * ctr + 2 * (h1 + v1) - (h2 + v2));
            opp = 8 * (12 * ctr + 4 * dg - 3 * (h2 + v2));
            hor = 8 * (10 * ctr + 8 * h1 - 2 * h2 - 2 * dg + v2);
            ver = 8 * (10 * ctr + 8 * v1 - 2 * v2 - 2 * dg + h2);
            ph = {1'(r - 2), 1'(c - 2)};
            case (ph)
                PH_R:    begin rr = pass; gg = grn;  bb = opp;  end
                PH_GR:   begin rr = hor;  gg = pass; bb = ver;  end
                PH_GB:   begin rr = ver;  gg = pass; bb = hor;  end
                default: begin rr = opp;  gg = grn;  bb = pass; end
            endcase
            e.red = saturate(rr);  e.green = saturate(gg);  e.blue = saturate(bb);
            // a flat field passes every kernel unchanged
            if (flat_color >= 0) begin
                e.red = 14'(flat_color);
                e.green = 14'(flat_color);
                e.blue = 14'(flat_color);
            end
            e.row = 13'(r - 2);
            e.col = 12'(c - 2);
            e.last = (r == h - 1 && c == w - 1);
            rgb_pending.push_back(e);
        end
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = (r >= h) ? 0 : r;
        end
    endfunction

    // starts and ends at a falling edge; valid stays up across back-to-back words
    task automatic send_pixel(input logic [13:0] pix);
        while (idle_on && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        demosaic_step(pix);
        @(negedge aclk);
    endtask

    // hold off until every word is out, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (rgb_pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value[13:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = value & 'h1FFF;
            REG_FRAME_HEIGHT: cfg_height = value & 'h3FFF;
            default:          cfg_pmax = value & 'h3FFF;
        endcase
    endtask

    function automatic logic [13:0] fill_pixel(fill_e f, int level, int r, int c);
        case (f)
            FILL_FLAT:    return level[13:0];
            FILL_CHECKER: return ((r + c) & 1) ? 14'h3FFF : 14'h0000;
            FILL_STRIPES: return ((c >> 1) & 1) ? 14'h3FFF : level[13:0];
            default: begin
                case ($urandom_range(3))
                    0:       return $urandom_range(1) ? 14'h3FFF : 14'h0000;
                    1:       return level[13:0] ^ 14'($urandom_range(63));
                    default: return 14'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic run_frame(input frame_row_t fr);
        int w, h;
        write_reg(REG_FRAME_WIDTH, fr.width);
        write_reg(REG_FRAME_HEIGHT, fr.height);
        write_reg(REG_PIXEL_MAX, fr.pmax);
        w = cfg_width;  h = cfg_height;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < MIN_SIZE) h = MIN_SIZE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        flat_color = fr.flat_color;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_pixel(fill_pixel(fr.fill, fr.level, r, c));
        drain();
        flat_color = -1;
        frames_sent++;
    endtask

    frame_row_t directed[] = '{
        '{8, 8, 16383, FILL_FLAT, 0, 0},
        '{8, 8, 16383, FILL_FLAT, 16383, 16383},
        '{9, 9, 1000, FILL_FLAT, 5000, 1000},
        '{8, 8, 0, FILL_FLAT, 16383, 0},
        '{10, 8, 16383, FILL_CHECKER, 0, -1},
        '{11, 10, 16383, FILL_STRIPES, 0, -1},
        '{0, 0, 16383, FILL_RANDOM, 8000, -1},
        '{9, 8, 1, FILL_RANDOM, 300, -1},
        '{12, 8, 16383, FILL_FLAT, 7, 7}
    };

    always @(negedge aclk) begin
        if (!idle_on) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        rgb_word_t e;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (rgb_pending.size() == 0) begin
                $error("unexpected word at row %0d col %0d", m_out_row, m_out_col);
                errors++;
            end else begin
                e = rgb_pending.pop_front();
                if (m_red !== e.red) begin
                    $error("red: expected %0d, got %0d", e.red, m_red);
                    errors++;
                end
                if (m_green !== e.green) begin
                    $error("green: expected %0d, got %0d", e.green, m_green);
                    errors++;
                end
                if (m_blue !== e.blue) begin
                    $error("blue: expected %0d, got %0d", e.blue, m_blue);
                    errors++;
                end
                if (m_out_row !== e.row) begin
                    $error("out_row: expected %0d, got %0d", e.row, m_out_row);
                    errors++;
                end
                if (m_out_col !== e.col) begin
                    $error("out_col: expected %0d, got %0d", e.col, m_out_col);
                    errors++;
                end
                if (m_frame_last !== e.last) begin
                    $error("frame_last: expected %0d, got %0d", e.last, m_frame_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        frame_row_t fr;
        int sent_random;
        int pm;
        col_pos = 0;
        row_pos = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) run_frame(directed[i]);

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            // the third random frame runs with both sides always ready
            idle_on = (frames_sent != directed.size() + 2);
            case ($urandom_range(5))
                0:       pm = 16383;
                1:       pm = $urandom_range(1, 255);
                2:       pm = 0;
                default: pm = $urandom_range(16383);
            endcase
            fr = '{$urandom_range(8, 20), $urandom_range(8, 12), pm,
                   ($urandom_range(4) == 0) ? FILL_STRIPES : FILL_RANDOM,
                   $urandom_range(16383), -1};
            run_frame(fr);
            sent_random += fr.width * fr.height;
        end
        idle_on = 1'b1;

        drain();
        $display("%0d frames, %0d RGB words checked; small frames up to 20x12,",
                 frames_sent, words_seen);
        $display("flat, checker, stripe and random fills, clamped sizes and saturation limits");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
